// File: hdl/lidarb_pkg.sv
// ----------------------------------------------------------------------------
// lidarb_pkg
// shared field widths, word layout offsets, defaults and operation codes
// ----------------------------------------------------------------------------
package lidarb_pkg;

  // fixed field widths
  localparam int unsigned OP_BITS    = 2;
  localparam int unsigned ID_BITS    = 29;
  localparam int unsigned PAYLOAD_W  = 64;
  localparam int unsigned NODE_BITS  = 8;
  localparam int unsigned RIDX_BITS  = 4;
  localparam int unsigned TOTAL_BITS = 32;

  // counter that walks the identifier bits, msb first
  localparam int unsigned BIT_CNT_W = $clog2(ID_BITS);

  // parameter defaults
  localparam int unsigned DEF_PENDING_SLOTS = 8;
  localparam int unsigned DEF_RING_SLOTS    = 16;
  localparam int unsigned DEF_PAYLOAD_BITS  = 64;

  // input word layout
  localparam int unsigned IN_ID_LSB   = 0;
  localparam int unsigned IN_PAY_LSB  = IN_ID_LSB + ID_BITS;
  localparam int unsigned IN_NODE_LSB = IN_PAY_LSB + PAYLOAD_W;
  localparam int unsigned IN_RIDX_LSB = IN_NODE_LSB + NODE_BITS;
  localparam int unsigned IN_USED_W   = IN_RIDX_LSB + RIDX_BITS;
  localparam int unsigned IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

  // output word layout
  localparam int unsigned OUT_NODE_LSB  = 0;
  localparam int unsigned OUT_ID_LSB    = OUT_NODE_LSB + NODE_BITS;
  localparam int unsigned OUT_PAY_LSB   = OUT_ID_LSB + ID_BITS;
  localparam int unsigned OUT_RIDX_LSB  = OUT_PAY_LSB + PAYLOAD_W;
  localparam int unsigned OUT_TOTAL_LSB = OUT_RIDX_LSB + RIDX_BITS;
  localparam int unsigned OUT_USED_W    = OUT_TOTAL_LSB + TOTAL_BITS;
  localparam int unsigned OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [OP_BITS-1:0] {
    OP_SUBMIT    = 2'd0,
    OP_ARBITRATE = 2'd1,
    OP_RECEIVE   = 2'd2
  } op_e;

endpackage

// File: hdl/lowest_id_arbiter_with_frame_ring_core.sv
// ----------------------------------------------------------------------------
// lowest_id_arbiter_with_frame_ring_core
// pending frame table with bit-serial lowest-identifier arbitration into a
// ring of bus slots, plus identifier lookup over the ring
// ----------------------------------------------------------------------------
//
// channel   dir  handshake                    tdata / tuser
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: op; tdata: msg_id, payload,
//                                             sender_node, read_index
// m_axis    out  m_axis_tvalid/m_axis_tready  tuser: status; tdata: winner_node,
//                                             out_id, out_payload,
//                                             next_read_index, total_frames
//
// one word at a time: a submit scans for a free slot; an arbitrate passes over
// the identifier bits msb first, scans for the surviving slot and writes the ring;
// a receive makes the same msb-first pass, then scans the ring from read_index
// failures found at accept (table full, nothing pending, unknown op) skip to ST_FIN
// async active-low reset clears valid bits, counts, pointers and handshake state
// a new word is taken while a result waits; a held result stalls the next one
// ----------------------------------------------------------------------------
module lowest_id_arbiter_with_frame_ring_core #(
  parameter int unsigned PENDING_SLOTS = lidarb_pkg::DEF_PENDING_SLOTS,
  parameter int unsigned RING_SLOTS    = lidarb_pkg::DEF_RING_SLOTS,
  parameter int unsigned PAYLOAD_BITS  = lidarb_pkg::DEF_PAYLOAD_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input words
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // msg_id, payload, sender_node, read_index (lsb first)
  input  logic [lidarb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // op
  input  logic [lidarb_pkg::OP_BITS-1:0]     s_axis_tuser,
  // result words
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // winner_node, out_id, out_payload, next_read_index, total_frames (lsb first)
  output logic [lidarb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // status
  output logic [0:0]                         m_axis_tuser
);

  localparam int unsigned P  = PENDING_SLOTS;
  localparam int unsigned R  = RING_SLOTS;
  localparam int unsigned PB = PAYLOAD_BITS;
  localparam int unsigned PW = (P > 1) ? $clog2(P) : 1;
  localparam int unsigned RW = $clog2(R);
  localparam int unsigned SW = (PW > RW) ? PW : RW;
  localparam int unsigned CW = $clog2(P + 1);
  localparam int unsigned IDB = lidarb_pkg::ID_BITS;
  localparam int unsigned BCW = lidarb_pkg::BIT_CNT_W;

  localparam logic [SW-1:0]  P_LAST    = SW'(P - 1);
  localparam logic [SW-1:0]  R_LAST    = SW'(R - 1);
  localparam logic [RW-1:0]  R_LAST_RW = RW'(R - 1);
  localparam logic [CW-1:0]  P_FULL    = CW'(P);
  localparam logic [8:0]     R_SLOTS9  = 9'(R);
  localparam logic [BCW-1:0] BIT_MSB   = BCW'(IDB - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BITS,
    ST_SCAN,
    ST_READ,
    ST_WRITE,
    ST_FIN
  } state_e;

  // control state
  state_e               st_q;
  lidarb_pkg::op_e      op_q;
  logic                 fail_q;
  logic [BCW-1:0]       bit_q;
  logic [SW-1:0]        scan_q;
  logic [SW-1:0]        steps_q;
  logic [SW-1:0]        idx_q;
  logic [P-1:0]         pend_valid_q;
  logic [CW-1:0]        pend_cnt_q;
  logic [R-1:0]         ring_valid_q;
  logic [RW-1:0]        wp_q;
  logic [lidarb_pkg::TOTAL_BITS-1:0] total_q;
  logic [P-1:0]         surv_p_q;
  logic [R-1:0]         surv_r_q;

  // output register
  logic                                 m_valid_q;
  logic                                 m_status_q;
  logic [lidarb_pkg::NODE_BITS-1:0]     m_node_q;
  logic [IDB-1:0]                       m_id_q;
  logic [PB-1:0]                        m_pay_q;
  logic [lidarb_pkg::RIDX_BITS-1:0]     m_ridx_q;
  logic [lidarb_pkg::TOTAL_BITS-1:0]    m_total_q;

  // captured word and winner identifier shift register
  logic [IDB-1:0]                       msg_id_q;
  logic [PB-1:0]                        pay_q;
  logic [lidarb_pkg::NODE_BITS-1:0]     node_q;
  logic [lidarb_pkg::RIDX_BITS-1:0]     ridx_q;
  logic [IDB-1:0]                       win_id_q;

  // identifier cells, one per slot
  logic [IDB-1:0] pend_id_q [P];
  logic [IDB-1:0] ring_id_q [R];

  // payload and node memories
  logic [PB-1:0]                    pend_pay_mem [P];
  logic [lidarb_pkg::NODE_BITS-1:0] pend_node_mem [P];
  logic [PB-1:0]                    ring_pay_mem [R];
  logic [PB-1:0]                    pend_pay_rd_q;
  logic [lidarb_pkg::NODE_BITS-1:0] pend_node_rd_q;
  logic [PB-1:0]                    ring_pay_rd_q;

  // combinational
  logic                  in_acc;
  lidarb_pkg::op_e       in_op;
  logic [P-1:0]          pid_bit;
  logic [R-1:0]          rid_bit;
  logic                  bus_bit;
  logic [P-1:0]          surv_p_nxt;
  logic [R-1:0]          surv_r_nxt;
  logic [8:0]            rmod;
  logic [RW-1:0]         start_r;
  logic                  hit;
  logic [SW-1:0]         scan_last;
  logic [SW-1:0]         scan_nxt;
  logic                  sub_wr;
  logic                  ring_wr;
  logic [RW-1:0]         idx_nxt_rw;
  logic [8:0]            idx_nxt9;
  logic                  recv_ok;
  logic                  out_ok;

  assign s_axis_tready = (st_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign in_op         = lidarb_pkg::op_e'(s_axis_tuser);

  // one identifier bit per slot, msb first
  always_comb begin
    for (int i = 0; i < P; i++) begin
      pid_bit[i] = pend_id_q[i][bit_q];
    end
    for (int k = 0; k < R; k++) begin
      rid_bit[k] = ring_id_q[k][bit_q];
    end
  end

  // dominant zero: any survivor with a zero pulls the bus low
  assign bus_bit    = ~|(surv_p_q & ~pid_bit);
  assign surv_p_nxt = surv_p_q & ~(pid_bit & {P{~bus_bit}});
  assign surv_r_nxt = surv_r_q & ~(rid_bit ^ {R{msg_id_q[bit_q]}});

  // reader start position, read_index modulo ring size
  always_comb begin
    rmod = 9'(ridx_q);
    for (int j = 0; j < 8; j++) begin
      if (rmod >= R_SLOTS9) begin
        rmod = rmod - R_SLOTS9;
      end
    end
  end
  assign start_r = rmod[RW-1:0];

  always_comb begin
    case (op_q)
      lidarb_pkg::OP_SUBMIT:    hit = ~pend_valid_q[scan_q[PW-1:0]];
      lidarb_pkg::OP_ARBITRATE: hit = surv_p_q[scan_q[PW-1:0]];
      lidarb_pkg::OP_RECEIVE:   hit = surv_r_q[scan_q[RW-1:0]];
      default:                  hit = 1'b0;
    endcase
  end

  assign scan_last = (op_q == lidarb_pkg::OP_RECEIVE) ? R_LAST : P_LAST;
  assign scan_nxt  = (op_q == lidarb_pkg::OP_RECEIVE && scan_q == R_LAST) ? '0
                   : scan_q + 1'b1;
  assign sub_wr    = (st_q == ST_SCAN) && hit && (op_q == lidarb_pkg::OP_SUBMIT);
  assign ring_wr   = (st_q == ST_WRITE);

  // reader position after the matched slot
  assign idx_nxt_rw = (idx_q[RW-1:0] == R_LAST_RW) ? '0 : idx_q[RW-1:0] + 1'b1;
  assign idx_nxt9   = 9'(idx_nxt_rw);
  assign recv_ok    = (op_q == lidarb_pkg::OP_RECEIVE) && !fail_q;
  assign out_ok     = ~m_valid_q | m_axis_tready;

  // control state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      op_q         <= lidarb_pkg::OP_SUBMIT;
      fail_q       <= 1'b0;
      bit_q        <= '0;
      scan_q       <= '0;
      steps_q      <= '0;
      idx_q        <= '0;
      pend_valid_q <= '0;
      pend_cnt_q   <= '0;
      ring_valid_q <= '0;
      wp_q         <= '0;
      total_q      <= '0;
      surv_p_q     <= '0;
      surv_r_q     <= '0;
      m_valid_q    <= 1'b0;
      m_status_q   <= 1'b0;
      m_node_q     <= '0;
      m_id_q       <= '0;
      m_pay_q      <= '0;
      m_ridx_q     <= '0;
      m_total_q    <= '0;
    end else begin
      // result word loads in the final state, else leaves on a ready sink
      if (st_q == ST_FIN && out_ok) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: begin
          if (in_acc) begin
            op_q    <= in_op;
            fail_q  <= 1'b0;
            bit_q   <= BIT_MSB;
            scan_q  <= '0;
            steps_q <= '0;
            case (in_op)
              lidarb_pkg::OP_SUBMIT: begin
                if (pend_cnt_q == P_FULL) begin
                  fail_q <= 1'b1;
                  st_q   <= ST_FIN;
                end else begin
                  st_q <= ST_SCAN;
                end
              end
              lidarb_pkg::OP_ARBITRATE: begin
                if (pend_cnt_q == '0) begin
                  fail_q <= 1'b1;
                  st_q   <= ST_FIN;
                end else begin
                  surv_p_q <= pend_valid_q;
                  st_q     <= ST_BITS;
                end
              end
              lidarb_pkg::OP_RECEIVE: begin
                surv_r_q <= ring_valid_q;
                st_q     <= ST_BITS;
              end
              default: begin
                fail_q <= 1'b1;
                st_q   <= ST_FIN;
              end
            endcase
          end
        end
        ST_BITS: begin
          if (op_q == lidarb_pkg::OP_ARBITRATE) begin
            surv_p_q <= surv_p_nxt;
          end else begin
            surv_r_q <= surv_r_nxt;
          end
          if (bit_q == '0) begin
            scan_q <= (op_q == lidarb_pkg::OP_RECEIVE) ? SW'(start_r) : '0;
            st_q   <= ST_SCAN;
          end else begin
            bit_q <= bit_q - 1'b1;
          end
        end
        ST_SCAN: begin
          if (hit) begin
            idx_q <= scan_q;
            if (op_q == lidarb_pkg::OP_SUBMIT) begin
              pend_valid_q[scan_q[PW-1:0]] <= 1'b1;
              pend_cnt_q                   <= pend_cnt_q + 1'b1;
              st_q                         <= ST_FIN;
            end else begin
              st_q <= ST_READ;
            end
          end else if (steps_q == scan_last) begin
            fail_q <= 1'b1;
            st_q   <= ST_FIN;
          end else begin
            scan_q  <= scan_nxt;
            steps_q <= steps_q + 1'b1;
          end
        end
        ST_READ: begin
          st_q <= (op_q == lidarb_pkg::OP_ARBITRATE) ? ST_WRITE : ST_FIN;
        end
        ST_WRITE: begin
          // winner goes on the bus: ring slot filled, pending slot freed
          pend_valid_q[idx_q[PW-1:0]] <= 1'b0;
          pend_cnt_q                  <= pend_cnt_q - 1'b1;
          ring_valid_q[wp_q]          <= 1'b1;
          wp_q                        <= (wp_q == R_LAST_RW) ? '0 : wp_q + 1'b1;
          total_q                     <= total_q + 1'b1;
          st_q                        <= ST_FIN;
        end
        ST_FIN: begin
          if (out_ok) begin
            m_status_q <= fail_q;
            m_node_q   <= (op_q == lidarb_pkg::OP_ARBITRATE && !fail_q) ? pend_node_rd_q
                        : '0;
            m_id_q     <= recv_ok ? msg_id_q : '0;
            m_pay_q    <= recv_ok ? ring_pay_rd_q : '0;
            m_ridx_q   <= recv_ok ? idx_nxt9[lidarb_pkg::RIDX_BITS-1:0] : ridx_q;
            m_total_q  <= total_q;
            st_q       <= ST_IDLE;
          end
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

  // captured word, winner identifier and identifier cells
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      msg_id_q <= s_axis_tdata[lidarb_pkg::IN_ID_LSB +: IDB];
      pay_q    <= s_axis_tdata[lidarb_pkg::IN_PAY_LSB +: PB];
      node_q   <= s_axis_tdata[lidarb_pkg::IN_NODE_LSB +: lidarb_pkg::NODE_BITS];
      ridx_q   <= s_axis_tdata[lidarb_pkg::IN_RIDX_LSB +: lidarb_pkg::RIDX_BITS];
    end
    // bus bits in order form the winning identifier
    if (st_q == ST_BITS && op_q == lidarb_pkg::OP_ARBITRATE) begin
      win_id_q <= {win_id_q[IDB-2:0], bus_bit};
    end
    if (sub_wr) begin
      pend_id_q[scan_q[PW-1:0]] <= msg_id_q;
    end
    if (ring_wr) begin
      ring_id_q[wp_q] <= win_id_q;
    end
  end

  // pending payload and node memories
  always_ff @(posedge clk_i) begin
    if (sub_wr) begin
      pend_pay_mem[scan_q[PW-1:0]]  <= pay_q;
      pend_node_mem[scan_q[PW-1:0]] <= node_q;
    end
    pend_pay_rd_q  <= pend_pay_mem[idx_q[PW-1:0]];
    pend_node_rd_q <= pend_node_mem[idx_q[PW-1:0]];
  end

  // ring payload memory
  always_ff @(posedge clk_i) begin
    if (ring_wr) begin
      ring_pay_mem[wp_q] <= pend_pay_rd_q;
    end
    ring_pay_rd_q <= ring_pay_mem[idx_q[RW-1:0]];
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {
    (lidarb_pkg::OUT_TDATA_W - lidarb_pkg::OUT_USED_W)'(0),
    m_total_q,
    m_ridx_q,
    (lidarb_pkg::PAYLOAD_W)'(m_pay_q),
    m_id_q,
    m_node_q
  };

`ifndef ASSERT_OFF
  a_pend_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_cnt_q == CW'($countones(pend_valid_q)))
    else $error("pending count out of step with valid bits");

  a_surv_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_BITS && op_q == lidarb_pkg::OP_ARBITRATE) |->
      ((surv_p_q & ~pend_valid_q) == '0))
    else $error("arbitration contender without a pending frame");

  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_WRITE) |=> (total_q == $past(total_q) + 1'b1))
    else $error("frame total not advanced on ring write");

  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= R_LAST_RW)
    else $error("ring write pointer beyond ring");
`endif

endmodule
